// ===== rtl/anp_pkg.sv =====
// Package for the ASCII number parser: widths, format and status codes, helpers.
package anp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int PROD_W     = VALUE_BITS + 4;
  localparam int CNT_W      = 4;
  localparam int FMT_W      = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // number_format codes
  localparam logic [FMT_W-1:0] FMT_HEX2  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_HEX4  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_HEX8  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_DEC8  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_DEC16 = 3'd4;
  localparam logic [FMT_W-1:0] FMT_DEC32 = 3'd5;
  localparam logic [FMT_W-1:0] FMT_SDEC  = 3'd6;
  localparam logic [FMT_W-1:0] FMT_UNUSED = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE     = 1'd1;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] UPPER_OFS  = 8'd55;
  localparam logic [7:0] LOWER_OFS  = 8'd87;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISSING  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_BAD_HEX  = 3'd3,
    ST_BAD_DEC  = 3'd4
  } anp_status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       arg_absent;
  } anp_item_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] value;
    anp_status_t           status;
  } anp_result_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = c - CHAR_0;
      return {1'b1, d[3:0]};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      d = c - UPPER_OFS;
      return {1'b1, d[3:0]};
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      d = c - LOWER_OFS;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ===== rtl/ascii_number_parser_unit.sv =====
// Top level of the ASCII number parser: stream ports, config registers, pipeline.
//
// Usage: one character of a command argument per in_ request, left to right.
// in_tdata[7:0] is the character, in_tlast marks the final character and
// in_tuser flags an absent argument (character ignored, request closes).
// Each closing request yields one out_ request: out_tdata carries the value
// (two's complement in signed mode, zero on error), out_tuser the status
// (ok, missing, overflow, bad hex, bad decimal). Other requests yield nothing.
// The cfg_ channel writes number_format (index 0) and max_value (index 1);
// it is always ready. The user must write it only while the parser is idle;
// the block itself does not enforce this. The closing request passes
// through the input register, then the result register, which drives
// out_tvalid. Throughput: one character per cycle, with a shift-add update
// of the accumulator for each. While a result waits on out_tready,
// characters that do not close an argument keep flowing; a closing one holds
// in the input register with in_tready low until the result is taken.
// Reset clears the parser state and sets number_format to unsigned 32-bit
// decimal and max_value to all ones.
module ascii_number_parser_unit
  import anp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // char_code[7:0]
  input  logic                  in_tlast,
  input  logic                  in_tuser,   // arg_absent
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VALUE_BITS-1:0] out_tdata,  // value[31:0]
  output logic [2:0]            out_tuser,  // status[2:0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data
);

  logic [FMT_W-1:0]      fmt_r;
  logic [VALUE_BITS-1:0] max_r;
  logic                  ivalid_r;
  anp_item_t             item_r;
  logic                  ovalid_r;
  logic [VALUE_BITS-1:0] oval_r;
  anp_status_t           ostat_r;
  anp_result_t           res;
  logic                  step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_DEC32;
      max_r <= {VALUE_BITS{1'b1}};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUMBER_FORMAT: fmt_r <= cfg_data[FMT_W-1:0];
        REG_MAX_VALUE:     max_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // the held character moves on unless it closes and the result slot is blocked
  assign step      = ivalid_r && (!ovalid_r || out_tready
                                  || !(item_r.last_char || item_r.arg_absent));
  assign in_tready = !ivalid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivalid_r <= 1'b0;
    end else if (in_tready) begin
      ivalid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.char_code  <= in_tdata;
      item_r.last_char  <= in_tlast;
      item_r.arg_absent <= in_tuser;
    end
  end

  anp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (item_r),
    .number_format (fmt_r),
    .max_value     (max_r),
    .result        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (step && res.done) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.done) begin
      oval_r  <= res.value;
      ostat_r <= res.status;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = oval_r;
  assign out_tuser  = ostat_r;

endmodule

// ===== rtl/anp_core.sv =====
// Parser state and per-character update; produces the result of a closing item.
module anp_core
  import anp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  anp_item_t             item,
  input  logic [FMT_W-1:0]      number_format,
  input  logic [VALUE_BITS-1:0] max_value,
  output anp_result_t           result
);

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  anp_status_t           err_r, err_nxt;
  logic                  neg_r, neg_nxt;
  logic                  start_r, start_nxt;
  logic                  badhex_r, badhex_nxt;

  logic [FMT_W-1:0]      fmt;
  logic [4:0]            nib;
  logic                  is_digit;
  logic [VALUE_BITS-1:0] limit;
  logic [PROD_W-1:0]     prod;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CNT_W-1:0]      hex_digits;
  logic                  closing;

  always_comb begin
    fmt        = (number_format == FMT_UNUSED) ? FMT_DEC32 : number_format;
    nib        = hex_nibble(item.char_code);
    is_digit   = (item.char_code >= CHAR_0) && (item.char_code <= CHAR_9);
    cnt_inc    = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    // 10 * acc + digit, wide enough that the range check is exact
    prod       = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)
               + PROD_W'(item.char_code - CHAR_0);
    case (fmt)
      FMT_DEC8:  limit = VALUE_BITS'(8'hFF);
      FMT_DEC16: limit = VALUE_BITS'(16'hFFFF);
      FMT_SDEC:  limit = (VALUE_BITS'(1) << (VALUE_BITS - 1)) - VALUE_BITS'(!neg_r);
      default:   limit = {VALUE_BITS{1'b1}};
    endcase
    case (fmt)
      FMT_HEX2: hex_digits = CNT_W'(2);
      FMT_HEX4: hex_digits = CNT_W'(4);
      default:  hex_digits = CNT_W'(8);
    endcase

    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    neg_nxt    = neg_r;
    badhex_nxt = badhex_r;
    start_nxt  = 1'b0;

    if (fmt <= FMT_HEX8) begin
      cnt_nxt = cnt_inc;
      if (!nib[4]) begin
        badhex_nxt = 1'b1;
      end else begin
        acc_nxt = {acc_r[VALUE_BITS-5:0], nib[3:0]};
      end
    end else if (err_r == ST_OK) begin
      if (fmt == FMT_SDEC && start_r && item.char_code == CHAR_MINUS) begin
        neg_nxt = 1'b1;
      end else if (!is_digit) begin
        err_nxt = ST_BAD_DEC;
      end else if (prod > PROD_W'(limit)) begin
        err_nxt = ST_OVERFLOW;
      end else begin
        acc_nxt = prod[VALUE_BITS-1:0];
        cnt_nxt = cnt_inc;
      end
    end

    result.value  = '0;
    result.status = ST_OK;
    if (item.arg_absent) begin
      result.status = ST_MISSING;
    end else if (fmt <= FMT_HEX8) begin
      if (cnt_nxt > hex_digits) begin
        result.status = ST_OVERFLOW;
      end else if (badhex_nxt) begin
        result.status = ST_BAD_HEX;
      end else begin
        result.value = acc_nxt;
      end
    end else if (err_nxt != ST_OK) begin
      result.status = err_nxt;
    end else if (cnt_nxt == '0) begin
      result.status = ST_BAD_DEC;
    end else if (fmt == FMT_SDEC) begin
      result.value = neg_nxt ? (~acc_nxt + 1'b1) : acc_nxt;
    end else if (acc_nxt > max_value) begin
      result.status = ST_OVERFLOW;
    end else begin
      result.value = acc_nxt;
    end

    closing     = item.last_char || item.arg_absent;
    result.done = closing;
    if (closing) begin
      acc_nxt    = '0;
      cnt_nxt    = '0;
      err_nxt    = ST_OK;
      neg_nxt    = 1'b0;
      badhex_nxt = 1'b0;
      start_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cnt_r    <= '0;
      err_r    <= ST_OK;
      neg_r    <= 1'b0;
      start_r  <= 1'b1;
      badhex_r <= 1'b0;
    end else if (step) begin
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      neg_r    <= neg_nxt;
      start_r  <= start_nxt;
      badhex_r <= badhex_nxt;
    end
  end

endmodule
